/* src/stbt_pkg.sv */
`timescale 1ns / 1ps
// Package for the supertrend band tracker: field widths, reset values,
// config register indexes and the sequencer state type. No dependencies.
package stbt_pkg;

    // Field widths
    localparam int PRICE_W     = 32;  // U16.16 prices, true range, ATR
    localparam int PERIOD_W    = 11;
    localparam int MULT_W      = 5;
    localparam int BAND_W      = 38;  // internal signed band width
    localparam int OUT_BAND_W  = 39;  // band width on the output beat
    localparam int SUM_W       = 42;  // warm-up true range sum
    localparam int DIST_W      = PRICE_W + MULT_W;
    localparam int DIVD_W      = 44;  // Wilder dividend: ATR*(P-1) + TR
    localparam int DIV_CNT_W   = $clog2(DIVD_W);
    localparam int IN_DATA_W   = 3 * PRICE_W;
    localparam int OUT_DATA_W  = 80;  // 1 + 39 + 39, padded to bytes

    // Period limits
    localparam int MAX_PERIOD_DEF = 1024;
    localparam int PERIOD_HW_MAX  = 2046;
    localparam int PERIOD_MIN     = 2;

    // Bar counter saturation
    localparam logic [PERIOD_W-1:0] IDX_LIMIT = '1;

    // Config reset values
    localparam logic [PERIOD_W-1:0] ATR_PERIOD_RST = PERIOD_W'(10);
    localparam logic [MULT_W-1:0]   BAND_MULT_RST  = MULT_W'(3);

    // Config register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATR_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MULT  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_SCHED,
        S_MUL,
        S_DIV,
        S_BAND,
        S_DECIDE
    } t_state;

endpackage

/* src/supertrend_band_tracker_core.sv */
`timescale 1ns / 1ps
// Supertrend band tracker: Wilder ATR, midpoint bands, ratchet and trend flip.
// Depends on stbt_pkg; the ATR division runs on one shared restoring divider.
//
//  channel   dir  beat fields (low bit first)              handshake
//  --------  ---  ---------------------------------------  ----------------------
//  s_axis    in   high_price, low_price, close_price       s_axis_tvalid/tready
//  m_axis    out  trend_up, lower_band, upper_band, pad    m_axis_tvalid/tready
//  cfg       in   i_cfg_index, i_cfg_data                  i_cfg_valid/o_cfg_ready
//
// During warm-up (bar index up to one below the period) a bar skips the
// divider. The bar that forms the first average (bar index equal to the
// period) runs the 44-step restoring divider, one quotient bit per cycle,
// and each Wilder update after it adds one multiply step before the divider.
// A new bar is taken only in the idle state; a finished result waits in the
// output register, and the next bar may be taken meanwhile. The sequencer
// holds in its last step until the output register is free.
// Reset (i_rst_n low at an edge) clears all but working regs; no clearing pass.
module supertrend_band_tracker_core #(
    parameter int MAX_PERIOD = stbt_pkg::MAX_PERIOD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input bars
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] high_price, [63:32] low_price, [95:64] close_price
    input  logic [stbt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] trend_up, [39:1] lower_band, [78:40] upper_band, [79] zero
    output logic [stbt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // config writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stbt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stbt_pkg::PERIOD_W-1:0]    i_cfg_data
);
    import stbt_pkg::*;

    localparam int EFF_MAX = (MAX_PERIOD > PERIOD_HW_MAX) ? PERIOD_HW_MAX : MAX_PERIOD;

    // Control and architectural state
    t_state                     r_state, n_state;
    logic [PERIOD_W-1:0]        r_atr_period;
    logic [MULT_W-1:0]          r_band_mult;
    logic [PERIOD_W-1:0]        r_bar_index, n_bar_index;
    logic [PRICE_W-1:0]         r_last_close, n_last_close;
    logic [SUM_W-1:0]           r_range_sum, n_range_sum;
    logic [PRICE_W-1:0]         r_avg_range, n_avg_range;
    logic signed [BAND_W-1:0]   r_last_lower, n_last_lower;
    logic signed [BAND_W-1:0]   r_last_upper, n_last_upper;
    logic                       r_last_up, n_last_up;
    logic                       r_out_valid, n_out_valid;

    // Per-bar working registers
    logic [PRICE_W-1:0]         r_hi, n_hi, r_lo, n_lo, r_cl, n_cl;
    logic [PERIOD_W-1:0]        r_period, n_period;
    logic [PRICE_W-1:0]         r_tr, n_tr;
    logic [PRICE_W-1:0]         r_mid, n_mid;
    logic [PRICE_W-1:0]         r_atr, n_atr;
    logic [DIST_W-1:0]          r_dist, n_dist;
    logic [DIVD_W-1:0]          r_quo, n_quo;
    logic [PERIOD_W-1:0]        r_rem, n_rem;
    logic [DIV_CNT_W-1:0]       r_div_cnt, n_div_cnt;
    logic [OUT_DATA_W-1:0]      r_out_data, n_out_data;

    // Combinational helpers
    logic [PERIOD_W-1:0]        period_eff;
    logic [PRICE_W-1:0]         tr_hl, tr_dh, tr_dl, tr_max1, tr_calc;
    logic [PRICE_W:0]           hl_sum;
    logic [SUM_W-1:0]           sum_add;
    logic [PERIOD_W:0]          rem_sh;
    logic                       quo_bit;
    logic [DIVD_W-1:0]          quo_next;
    logic signed [BAND_W-1:0]   cl_s, lower_raw, upper_raw;
    logic                       take_out;
    logic                       dec_up;
    logic signed [BAND_W-1:0]   dec_lower, dec_upper;

    // Effective period clamp
    always_comb begin
        period_eff = r_atr_period;
        if (r_atr_period < PERIOD_W'(PERIOD_MIN)) period_eff = PERIOD_W'(PERIOD_MIN);
        if (r_atr_period > PERIOD_W'(EFF_MAX))    period_eff = PERIOD_W'(EFF_MAX);
    end

    // True range against the previous close
    always_comb begin
        tr_hl   = (r_hi > r_lo) ? r_hi - r_lo : '0;
        tr_dh   = (r_hi >= r_last_close) ? r_hi - r_last_close : r_last_close - r_hi;
        tr_dl   = (r_lo >= r_last_close) ? r_lo - r_last_close : r_last_close - r_lo;
        tr_max1 = (tr_dh > tr_hl) ? tr_dh : tr_hl;
        tr_calc = (tr_dl > tr_max1) ? tr_dl : tr_max1;
    end

    assign hl_sum  = {1'b0, r_hi} + {1'b0, r_lo};
    assign sum_add = r_range_sum + {{(SUM_W-PRICE_W){1'b0}}, r_tr};

    // Restoring divider step: one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[DIVD_W-1]};
    assign quo_bit  = (rem_sh >= {1'b0, r_period});
    assign quo_next = {r_quo[DIVD_W-2:0], quo_bit};

    // Band candidates and trend decision
    assign cl_s      = $signed({{(BAND_W-PRICE_W){1'b0}}, r_cl});
    assign lower_raw = $signed({{(BAND_W-PRICE_W){1'b0}}, r_mid})
                     - $signed({{(BAND_W-DIST_W){1'b0}}, r_dist});
    assign upper_raw = $signed({{(BAND_W-PRICE_W){1'b0}}, r_mid})
                     + $signed({{(BAND_W-DIST_W){1'b0}}, r_dist});

    always_comb begin
        dec_lower = lower_raw;
        dec_upper = upper_raw;
        if (r_bar_index == '0) begin
            dec_up = 1'b1;
        end else if (cl_s > r_last_upper) begin
            dec_up = 1'b1;
        end else if (cl_s < r_last_lower) begin
            dec_up = 1'b0;
        end else begin
            dec_up = r_last_up;
            if (r_last_up && (lower_raw < r_last_lower)) dec_lower = r_last_lower;
            if (!r_last_up && (upper_raw > r_last_upper)) dec_upper = r_last_upper;
        end
    end

    assign take_out = !r_out_valid || m_axis_tready;

    // Sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_bar_index  = r_bar_index;
        n_last_close = r_last_close;
        n_range_sum  = r_range_sum;
        n_avg_range  = r_avg_range;
        n_last_lower = r_last_lower;
        n_last_upper = r_last_upper;
        n_last_up    = r_last_up;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_cl         = r_cl;
        n_period     = r_period;
        n_tr         = r_tr;
        n_mid        = r_mid;
        n_atr        = r_atr;
        n_dist       = r_dist;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div_cnt    = r_div_cnt;
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_hi     = s_axis_tdata[PRICE_W-1:0];
                    n_lo     = s_axis_tdata[2*PRICE_W-1:PRICE_W];
                    n_cl     = s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
                    n_period = period_eff;
                    n_state  = S_RANGE;
                end
            end
            S_RANGE: begin
                n_tr    = tr_calc;
                n_mid   = hl_sum[PRICE_W:1];
                n_state = S_SCHED;
            end
            S_SCHED: begin
                n_rem     = '0;
                n_div_cnt = '0;
                if (r_bar_index == '0) begin
                    n_atr   = '0;
                    n_state = S_BAND;
                end else if (r_bar_index < r_period) begin
                    n_range_sum = sum_add;
                    n_atr       = '0;
                    n_state     = S_BAND;
                end else if (r_bar_index == r_period) begin
                    // first average: warm-up sum over the period
                    n_range_sum = sum_add;
                    n_quo       = {{(DIVD_W-SUM_W){1'b0}}, sum_add};
                    n_state     = S_DIV;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Wilder update dividend: ATR * (P - 1) + TR
                n_quo = ({{(DIVD_W-PRICE_W){1'b0}}, r_avg_range}
                         * {{(DIVD_W-PERIOD_W){1'b0}}, r_period - PERIOD_W'(1)})
                      + {{(DIVD_W-PRICE_W){1'b0}}, r_tr};
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo     = quo_next;
                n_rem     = quo_bit ? PERIOD_W'(rem_sh - {1'b0, r_period})
                                    : rem_sh[PERIOD_W-1:0];
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIVD_W-1)) begin
                    n_avg_range = quo_next[PRICE_W-1:0];
                    n_atr       = quo_next[PRICE_W-1:0];
                    n_state     = S_BAND;
                end
            end
            S_BAND: begin
                n_dist  = {{MULT_W{1'b0}}, r_atr} * {{PRICE_W{1'b0}}, r_band_mult};
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (take_out) begin
                    n_last_lower = dec_lower;
                    n_last_upper = dec_upper;
                    n_last_up    = dec_up;
                    n_last_close = r_cl;
                    if (r_bar_index != IDX_LIMIT) n_bar_index = r_bar_index + PERIOD_W'(1);
                    n_out_valid  = 1'b1;
                    n_out_data   = {1'b0,
                                    dec_upper[BAND_W-1], dec_upper,
                                    dec_lower[BAND_W-1], dec_lower,
                                    dec_up};
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Architectural state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atr_period <= ATR_PERIOD_RST;
            r_band_mult  <= BAND_MULT_RST;
            r_bar_index  <= '0;
            r_last_close <= '0;
            r_range_sum  <= '0;
            r_avg_range  <= '0;
            r_last_lower <= '0;
            r_last_upper <= '0;
            r_last_up    <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_bar_index  <= n_bar_index;
            r_last_close <= n_last_close;
            r_range_sum  <= n_range_sum;
            r_avg_range  <= n_avg_range;
            r_last_lower <= n_last_lower;
            r_last_upper <= n_last_upper;
            r_last_up    <= n_last_up;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ATR_PERIOD: r_atr_period <= i_cfg_data;
                    CFG_BAND_MULT:  r_band_mult  <= i_cfg_data[MULT_W-1:0];
                    default:        r_band_mult  <= r_band_mult;
                endcase
            end
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_cl       <= n_cl;
        r_period   <= n_period;
        r_tr       <= n_tr;
        r_mid      <= n_mid;
        r_atr      <= n_atr;
        r_dist     <= n_dist;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div_cnt  <= n_div_cnt;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    // Checks
    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_cnt < DIV_CNT_W'(DIVD_W)))
        else $error("divider step count out of range");

    a_rem_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_period))
        else $error("divider remainder not below period");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("bar taken while previous bar in progress");

    a_load_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DECIDE))
        else $error("result loaded outside the decide step");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for supertrend_band_tracker_core: streams price bars, predicts ATR,
// bands and trend per bar, and checks every result beat. Depends on stbt_pkg and the core.
module tb_top;
    import stbt_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 60;      // one Wilder bar plus margin
    localparam int MAX_LOGGED  = 100;     // keep the log short on a bad run

    typedef struct packed {
        logic                  trend_up;
        logic [OUT_BAND_W-1:0] lower_band;
        logic [OUT_BAND_W-1:0] upper_band;
    } t_bar_result;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_ATR_PERIOD;
    logic [PERIOD_W-1:0]    i_cfg_data    = '0;

    supertrend_band_tracker_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow of the core: register copies and band tracker state
    logic [PERIOD_W-1:0]  cfg_period = ATR_PERIOD_RST;
    logic [MULT_W-1:0]    cfg_mult   = BAND_MULT_RST;
    logic [PERIOD_W-1:0]  bar_idx    = '0;
    logic [PRICE_W-1:0]   prev_close = '0;
    logic [SUM_W-1:0]     tr_sum     = '0;
    logic [PRICE_W-1:0]   atr_q      = '0;
    longint               prev_lower = 0;
    longint               prev_upper = 0;
    logic                 prev_up    = 1'b1;

    t_bar_result bar_results_due[$];
    int          mismatches   = 0;
    int          beats_seen   = 0;
    int          cycle_count  = 0;
    int          burst_left   = 0;

    // Synthetic market for random bars
    longint walk_base = 64'h8000_0000;
    longint walk_vol  = 64'h100;

    // Advance the shadow state by one bar and return the result it must produce
    function automatic t_bar_result track_bar(input logic [PRICE_W-1:0] hi, lo, cl);
        longint unsigned p, tr, d, atr, mid, spread;
        longint          lower, upper;
        logic            up;
        t_bar_result     r;
        p = 64'(cfg_period);
        if (p < 64'(PERIOD_MIN)) p = 64'(PERIOD_MIN);
        if (p > 64'(MAX_PERIOD_DEF)) p = 64'(MAX_PERIOD_DEF);
        if (p > 64'(PERIOD_HW_MAX)) p = 64'(PERIOD_HW_MAX);
        atr = 0;
        if (bar_idx != 0) begin
            // true range against the previous close; high below low adds nothing
            tr = (hi > lo) ? 64'(hi - lo) : 64'd0;
            d = (hi >= prev_close) ? 64'(hi - prev_close) : 64'(prev_close - hi);
            if (d > tr) tr = d;
            d = (lo >= prev_close) ? 64'(lo - prev_close) : 64'(prev_close - lo);
            if (d > tr) tr = d;
            if (bar_idx < p) begin
                tr_sum = tr_sum + tr[SUM_W-1:0];
            end else if (bar_idx == p) begin
                tr_sum = tr_sum + tr[SUM_W-1:0];
                atr_q  = PRICE_W'(64'(tr_sum) / p);
                atr    = 64'(atr_q);
            end else begin
                atr_q = PRICE_W'((64'(atr_q) * (p - 1) + tr) / p);
                atr   = 64'(atr_q);
            end
        end
        mid    = (64'(hi) + 64'(lo)) >> 1;
        spread = atr * 64'(cfg_mult);
        lower  = longint'(mid) - longint'(spread);
        upper  = longint'(mid) + longint'(spread);
        // flip on a band cross, else hold and ratchet the active side
        if (bar_idx == 0) begin
            up = 1'b1;
        end else if (longint'(64'(cl)) > prev_upper) begin
            up = 1'b1;
        end else if (longint'(64'(cl)) < prev_lower) begin
            up = 1'b0;
        end else begin
            up = prev_up;
            if (up && lower < prev_lower) lower = prev_lower;
            if (!up && upper > prev_upper) upper = prev_upper;
        end
        prev_lower = lower;
        prev_upper = upper;
        prev_up    = up;
        prev_close = cl;
        if (bar_idx != IDX_LIMIT) bar_idx = bar_idx + 1'b1;
        r.trend_up   = up;
        r.lower_band = lower[OUT_BAND_W-1:0];
        r.upper_band = upper[OUT_BAND_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (mismatches < MAX_LOGGED)
            $display("[%0t] beat %0d %s: expected %h got %h", $time, beats_seen, what,
                     want, got);
        mismatches++;
    endtask

    // Result checker: every accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (bar_results_due.size() == 0) begin
                report_mismatch("unexpected beat", 64'd0, m_axis_tdata[63:0]);
            end else begin
                t_bar_result want;
                want = bar_results_due.pop_front();
                if (m_axis_tdata[0] !== want.trend_up)
                    report_mismatch("trend_up", 64'(want.trend_up), 64'(m_axis_tdata[0]));
                if (m_axis_tdata[39:1] !== want.lower_band)
                    report_mismatch("lower_band", 64'(want.lower_band),
                                    64'(m_axis_tdata[39:1]));
                if (m_axis_tdata[78:40] !== want.upper_band)
                    report_mismatch("upper_band", 64'(want.upper_band),
                                    64'(m_axis_tdata[78:40]));
                if (m_axis_tdata[79] !== 1'b0)
                    report_mismatch("pad bit", 64'd0, 64'(m_axis_tdata[79]));
            end
            beats_seen++;
        end
    end

    // Receiver backpressure: modes of free flow, coin-flip and long stalls
    int rx_mode = 0;
    int rx_left = 0;
    int rx_hold = 0;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold > 0) begin
                    m_axis_tready = 1'b0;
                    rx_hold--;
                end else begin
                    m_axis_tready = 1'b1;
                    if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 30);
                end
            end
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("supertrend_band_tracker_core verification failed");
            $finish;
        end
    end

    // Send one bar; the sender runs in bursts with random gaps between them
    task automatic send_bar(input logic [PRICE_W-1:0] hi, lo, cl);
        int          gap;
        t_bar_result due;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge i_clk) s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {cl, lo, hi};
        do @(posedge i_clk); while (!s_axis_tready);
        due = track_bar(hi, lo, cl);
        bar_results_due = {bar_results_due, due};
    endtask

    // Stop sending and wait until every predicted beat has come back
    task automatic wait_idle();
        @(negedge i_clk) s_axis_tvalid = 1'b0;
        while (bar_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ATR_PERIOD) cfg_period = val;
        else cfg_mult = val[MULT_W-1:0];
        @(negedge i_clk) i_cfg_valid = 1'b0;
    endtask

    // New volatility and price level for the synthetic market
    task automatic shift_market();
        walk_vol  = longint'(1) << $urandom_range(2, 24);
        walk_base = longint'($urandom_range(32'h0100_0000, 32'hF000_0000));
    endtask

    function automatic logic [PRICE_W-1:0] clamp_price(input longint v);
        if (v < 0) return '0;
        if (v > 64'hFFFF_FFFF) return '1;
        return v[PRICE_W-1:0];
    endfunction

    // Mostly a drifting market with coherent bars; some pure noise and
    // some bars with high below low or the close outside the bar
    task automatic next_bar(output logic [PRICE_W-1:0] hi, lo, cl);
        longint h, l, c;
        logic [PRICE_W-1:0] t;
        if ($urandom_range(0, 63) == 0) shift_market();
        if ($urandom_range(0, 7) == 0) begin
            hi = $urandom;
            lo = $urandom;
            cl = $urandom;
        end else begin
            walk_base = walk_base + longint'($urandom_range(0, 32'(4 * walk_vol)))
                        - 2 * walk_vol;
            walk_base = longint'(64'(clamp_price(walk_base)));
            h = walk_base + longint'($urandom_range(0, 32'(walk_vol)));
            l = walk_base - longint'($urandom_range(0, 32'(walk_vol)));
            if ($urandom_range(0, 9) == 0)
                c = walk_base + longint'($urandom_range(0, 32'(6 * walk_vol))) - 3 * walk_vol;
            else
                c = l + longint'($urandom_range(0, 32'(h - l)));
            hi = clamp_price(h);
            lo = clamp_price(l);
            cl = clamp_price(c);
            if ($urandom_range(0, 15) == 0) begin
                t  = hi;
                hi = lo;
                lo = t;
            end
        end
    endtask

    task automatic send_random_bars(input int count);
        logic [PRICE_W-1:0] hi, lo, cl;
        repeat (count) begin
            next_bar(hi, lo, cl);
            send_bar(hi, lo, cl);
        end
    endtask

    // Reset settings: first bar, warm-up through the first average, field extremes
    task automatic test_warmup_extremes();
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_bar(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'h0001_0000, 32'h0002_0000, 32'h0000_0000);
        send_bar(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
        send_bar(32'h5555_5555, 32'h0000_0000, 32'hAAAA_AAAA);
        send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
        send_bar(32'h0000_FFFF, 32'h0000_0001, 32'hFFFF_0000);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);  // average formed here
        send_bar(32'h1234_5678, 32'h1234_0000, 32'h1234_5000);  // first Wilder update
    endtask

    // Multiplier zero collapses both bands onto the midpoint; period 1 acts as 2
    task automatic test_zero_multiplier();
        wait_idle();
        write_reg(CFG_ATR_PERIOD, PERIOD_W'(1));
        write_reg(CFG_BAND_MULT, PERIOD_W'(0));
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_bar(32'h0000_0010, 32'h0000_0020, 32'h0000_0000);
        shift_market();
        send_random_bars(2);
    endtask

    // Hold with ratchet, then a flip down and a flip back up; multiplier 16
    task automatic test_trend_flips();
        wait_idle();
        write_reg(CFG_ATR_PERIOD, PERIOD_W'(0));
        write_reg(CFG_BAND_MULT, PERIOD_W'(16));
        repeat (4) send_bar(32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
        send_bar(32'h4000_0000, 32'h4000_0000, 32'h0000_0000);
        send_bar(32'h3FF0_0000, 32'h3FF0_0000, 32'h3FF0_0000);
        send_bar(32'h4000_0000, 32'h4000_0000, 32'hFFFF_FFFF);
    endtask

    // Period raised past the bar count: warm-up resumes on the kept sum and
    // the full-length average forms at bar 1024
    task automatic test_long_warmup();
        wait_idle();
        write_reg(CFG_ATR_PERIOD, PERIOD_W'(MAX_PERIOD_DEF));
        write_reg(CFG_BAND_MULT, PERIOD_W'(1));
        shift_market();
        send_random_bars(MAX_PERIOD_DEF + 40 - int'(bar_idx));
    endtask

    // Phases with assorted register settings, out-of-range ones included
    task automatic test_random_settings();
        logic [PERIOD_W-1:0] period_val, mult_val;
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: period_val = PERIOD_W'(PERIOD_MIN);
                1: period_val = PERIOD_W'(MAX_PERIOD_DEF);
                2: period_val = '1;
                3: period_val = PERIOD_W'($urandom_range(0, 1));
                4: period_val = PERIOD_W'($urandom_range(2, 64));
                default: period_val = PERIOD_W'($urandom_range(2, 2047));
            endcase
            case ($urandom_range(0, 4))
                0: mult_val = PERIOD_W'(0);
                1: mult_val = PERIOD_W'(1);
                2: mult_val = PERIOD_W'(16);
                3: mult_val = PERIOD_W'(31);
                default: mult_val = PERIOD_W'($urandom_range(1, 16));
            endcase
            // upper data bits are don't-care for the multiplier
            mult_val[PERIOD_W-1:MULT_W] = (PERIOD_W-MULT_W)'($urandom);
            if (ph == 0) period_val = '1;
            if (ph == 1) mult_val = PERIOD_W'(31);
            if (ph < 2 || $urandom_range(0, 3) != 0) write_reg(CFG_ATR_PERIOD, period_val);
            if (ph < 2 || $urandom_range(0, 3) != 0) write_reg(CFG_BAND_MULT, mult_val);
            shift_market();
            send_random_bars(45);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        test_warmup_extremes();
        test_zero_multiplier();
        test_trend_flips();
        test_long_warmup();
        test_random_settings();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("supertrend_band_tracker_core verification clean");
        else
            $display("supertrend_band_tracker_core verification failed");
        $finish;
    end

endmodule
